[src/iaf_pkg.sv]
// Shared types and constants of the IMU alignment and gravity filter.
// Used by iaf_front, iaf_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package iaf_pkg;

    localparam int AXES   = 3;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Reset value of the gravity estimate Z axis, -9.81 in Q7.24
    localparam logic signed [31:0] GRAV_RESET_Z = -32'sd164584489;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_COS_PITCH = 3'd0,
        REG_SIN_PITCH = 3'd1,
        REG_COS_ROLL  = 3'd2,
        REG_SIN_ROLL  = 3'd3,
        REG_ALPHA     = 3'd4,
        REG_BIAS_X    = 3'd5,
        REG_BIAS_Y    = 3'd6,
        REG_BIAS_Z    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] cos_pitch;
        logic [15:0] sin_pitch;
        logic [15:0] cos_roll;
        logic [15:0] sin_roll;
        logic [15:0] alpha;
        logic [AXES-1:0][15:0] bias;
    } cfg_t;

    // One queued sample: raw accel and bias-removed gyro (exact in 17 bits)
    typedef struct packed {
        logic [AXES-1:0][15:0] accel;
        logic [AXES-1:0][16:0] gyro;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } front_stat_t;

    typedef struct packed {
        logic load;
        logic write;
    } back_stat_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_RUN,
        B_DRAIN,
        B_FIN,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

[src/imu_align_gravity_filter_top.sv]
// Top level of the IMU alignment and gravity filter: configuration
// registers, front end and back end. Depends on iaf_pkg, iaf_front, iaf_back.
`timescale 1ns / 1ps
`default_nettype none

// Each sample transaction pushed in is bias-corrected, rotated by the
// pitch/roll matrix and folded into a low-pass gravity estimate; exactly one
// result transaction comes out per sample, in order. In the back end one shared
// 18x32 multiplier works through 28 products (4 matrix terms, 9 per rotated
// vector, 2 per gravity axis), plus a load, a pipeline drain, the gravity
// rounding and the result write. A two-entry input queue takes new samples
// while the back end works, and a one-entry result register holds the finished
// result until it is popped. The user must write registers through
// cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block does not enforce it.
module imu_align_gravity_filter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] accel_x,
    input  wire logic [15:0] accel_y,
    input  wire logic [15:0] accel_z,
    input  wire logic [15:0] gyro_x,
    input  wire logic [15:0] gyro_y,
    input  wire logic [15:0] gyro_z,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      corr_accel_x,
    output logic [15:0]      corr_accel_y,
    output logic [15:0]      corr_accel_z,
    output logic [15:0]      corr_gyro_x,
    output logic [15:0]      corr_gyro_y,
    output logic [15:0]      corr_gyro_z,
    output logic [15:0]      grav_x,
    output logic [15:0]      grav_y,
    output logic [15:0]      grav_z,
    output logic [15:0]      lin_x,
    output logic [15:0]      lin_y,
    output logic [15:0]      lin_z
);
    import iaf_pkg::*;

    cfg_t        cfg_reg;
    item_t       q_head;
    logic        q_valid;
    logic        q_pop;
    front_stat_t fstat;
    back_stat_t  bstat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_pitch <= 16'd32767;
            cfg_reg.sin_pitch <= '0;
            cfg_reg.cos_roll  <= 16'd32767;
            cfg_reg.sin_roll  <= '0;
            cfg_reg.alpha     <= 16'd64674;
            cfg_reg.bias      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_COS_PITCH: cfg_reg.cos_pitch <= cfg_wdata;
                REG_SIN_PITCH: cfg_reg.sin_pitch <= cfg_wdata;
                REG_COS_ROLL:  cfg_reg.cos_roll  <= cfg_wdata;
                REG_SIN_ROLL:  cfg_reg.sin_roll  <= cfg_wdata;
                REG_ALPHA:     cfg_reg.alpha     <= cfg_wdata;
                REG_BIAS_X:    cfg_reg.bias[0]   <= cfg_wdata;
                REG_BIAS_Y:    cfg_reg.bias[1]   <= cfg_wdata;
                REG_BIAS_Z:    cfg_reg.bias[2]   <= cfg_wdata;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    iaf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .accel_x (accel_x),
        .accel_y (accel_y),
        .accel_z (accel_z),
        .gyro_x  (gyro_x),
        .gyro_y  (gyro_y),
        .gyro_z  (gyro_z),
        .cfg     (cfg_reg),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .fstat   (fstat)
    );

    iaf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_head       (q_head),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .corr_accel_x (corr_accel_x),
        .corr_accel_y (corr_accel_y),
        .corr_accel_z (corr_accel_z),
        .corr_gyro_x  (corr_gyro_x),
        .corr_gyro_y  (corr_gyro_y),
        .corr_gyro_z  (corr_gyro_z),
        .grav_x       (grav_x),
        .grav_y       (grav_y),
        .grav_z       (grav_z),
        .lin_x        (lin_x),
        .lin_y        (lin_y),
        .lin_z        (lin_z),
        .bstat        (bstat)
    );

`ifndef ASSERT_OFF
    // Back end only takes a sample the queue actually holds
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    // Queue fill count stays within its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.count <= QCNT_W'(QDEPTH))
        else $error("input queue overfilled");

    // A result appears only after the back end wrote it
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(!empty) |-> $past(bstat.write))
        else $error("result valid without a back-end write");

    // One sample at a time: no second load right after a load
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.load |=> !q_pop)
        else $error("back end loaded two samples back to back");
`endif

endmodule

`default_nettype wire

[src/iaf_front.sv]
// Front end: takes sample transactions, removes the gyro bias and holds
// the samples in a short queue for the back end. Depends on iaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iaf_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [15:0]         accel_x,
    input  wire logic [15:0]         accel_y,
    input  wire logic [15:0]         accel_z,
    input  wire logic [15:0]         gyro_x,
    input  wire logic [15:0]         gyro_y,
    input  wire logic [15:0]         gyro_z,
    input  wire iaf_pkg::cfg_t       cfg,
    output iaf_pkg::item_t           q_head,
    output logic                     q_valid,
    input  wire logic                q_pop,
    output iaf_pkg::front_stat_t     fstat
);
    import iaf_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              do_pop;
    item_t             in_item;
    logic [AXES-1:0][15:0] raw_gyro;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign accept  = push && !full;
    assign do_pop  = q_pop && q_valid;
    assign q_head  = mem_reg[rd_ptr_reg];
    assign fstat.count = count_reg;

    // Pack the incoming sample, gyro minus bias in 17 bits
    assign raw_gyro = {gyro_z, gyro_y, gyro_x};
    always_comb
    begin
        in_item.accel = {accel_z, accel_y, accel_x};
        for (int i = 0; i < AXES; i++)
        begin
            in_item.gyro[i] = $signed({raw_gyro[i][15], raw_gyro[i]})
                            - $signed({cfg.bias[i][15], cfg.bias[i]});
        end
    end

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

[src/iaf_back.sv]
// Back end: one shared multiplier sequenced over the matrix, the two
// rotations and the gravity low-pass, plus the result register. Uses iaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iaf_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire iaf_pkg::cfg_t   cfg,
    input  wire iaf_pkg::item_t  q_head,
    input  wire logic            q_valid,
    output logic                 q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic [15:0]          corr_accel_x,
    output logic [15:0]          corr_accel_y,
    output logic [15:0]          corr_accel_z,
    output logic [15:0]          corr_gyro_x,
    output logic [15:0]          corr_gyro_y,
    output logic [15:0]          corr_gyro_z,
    output logic [15:0]          grav_x,
    output logic [15:0]          grav_y,
    output logic [15:0]          grav_z,
    output logic [15:0]          lin_x,
    output logic [15:0]          lin_y,
    output logic [15:0]          lin_z,
    output iaf_pkg::back_stat_t  bstat
);
    import iaf_pkg::*;

    typedef enum logic [1:0] {
        PH_MAT,
        PH_ROT,
        PH_GRAV
    } phase_t;

    typedef struct packed {
        phase_t     ph;
        logic       vec;   // 0: accel, 1: gyro
        logic [1:0] row;
        logic [1:0] col;
    } op_t;

    localparam op_t OP_FIRST = '{ph: PH_MAT, vec: 1'b0, row: 2'd0, col: 2'd0};

    function automatic logic [15:0] sat16(input logic signed [36:0] x);
        logic [15:0] r;
        if (x > 37'sd32767)
        begin
            r = 16'h7fff;
        end
        else if (x < -37'sd32768)
        begin
            r = 16'h8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

    // Walk matrix products, accel rows, gyro rows, then gravity axes
    function automatic op_t next_op(input op_t op);
        op_t n;
        n = op;
        unique case (op.ph)
            PH_MAT:
            begin
                if (op.col == 2'd3)
                begin
                    n = '{ph: PH_ROT, vec: 1'b0, row: 2'd0, col: 2'd0};
                end
                else
                begin
                    n.col = op.col + 2'd1;
                end
            end
            PH_ROT:
            begin
                if (op.col != 2'd2)
                begin
                    n.col = op.col + 2'd1;
                end
                else
                begin
                    n.col = 2'd0;
                    if (op.row != 2'd2)
                    begin
                        n.row = op.row + 2'd1;
                    end
                    else if (!op.vec)
                    begin
                        n.row = 2'd0;
                        n.vec = 1'b1;
                    end
                    else
                    begin
                        n = '{ph: PH_GRAV, vec: 1'b0, row: 2'd0, col: 2'd0};
                    end
                end
            end
            PH_GRAV:
            begin
                if (op.col == 2'd0)
                begin
                    n.col = 2'd1;
                end
                else if (op.row == 2'd2)
                begin
                    // Last product of the sample: park on the first op
                    n = OP_FIRST;
                end
                else
                begin
                    n.col = 2'd0;
                    n.row = op.row + 2'd1;
                end
            end
            default: n = op;
        endcase
        return n;
    endfunction

    back_state_t state_reg, state_next;
    op_t         op_reg, tag_reg;
    logic        tag_vld_reg;
    logic        last_op;
    logic        load;
    logic        issue;
    logic        out_free;
    logic        write_out;

    // Working registers of one sample
    logic [AXES-1:0][15:0] va_reg;
    logic [AXES-1:0][16:0] vg_reg;
    logic signed [16:0]    m01_reg, m02_reg, m21_reg, m22_reg;
    logic [AXES-1:0][15:0] ca_reg, cg_reg, gr_reg;
    logic signed [31:0]    g_reg [AXES];
    logic signed [49:0]    prod_reg;
    logic signed [51:0]    acc_reg;

    // Result register
    logic                  out_valid_reg;
    logic [AXES-1:0][15:0] o_ca_reg, o_cg_reg, o_gr_reg, o_ln_reg;

    // Multiplier operands and datapath
    logic signed [17:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [16:0] m_sel;
    logic signed [51:0] prod_ext, sum_rot, rot_rnd, mix, g_rnd, mat_rnd;

    assign last_op  = (op_reg.ph == PH_GRAV) && (op_reg.row == 2'd2) && (op_reg.col == 2'd1);
    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_valid) state_next = B_RUN;
            B_RUN:   if (last_op) state_next = B_DRAIN;
            B_DRAIN: state_next = B_FIN;
            B_FIN:   state_next = B_DONE;
            B_DONE:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        load      = (state_reg == B_IDLE) && q_valid;
        issue     = (state_reg == B_RUN);
        write_out = (state_reg == B_DONE) && out_free;
    end

    assign q_pop       = load;
    assign bstat.load  = load;
    assign bstat.write = write_out;

    // Sequencer, plus the tag that follows each product through the multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            op_reg      <= OP_FIRST;
            tag_reg     <= OP_FIRST;
            tag_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tag_reg     <= op_reg;
            tag_vld_reg <= issue;
            if (load)
            begin
                op_reg <= OP_FIRST;
            end
            else if (issue)
            begin
                op_reg <= next_op(op_reg);
            end
        end
    end

    // Matrix entry for the current rotation product
    always_comb
    begin
        m_sel = '0;
        unique case (op_reg.row)
            2'd0:
            begin
                unique case (op_reg.col)
                    2'd0:    m_sel = $signed({cfg.cos_pitch[15], cfg.cos_pitch});
                    2'd1:    m_sel = m01_reg;
                    2'd2:    m_sel = m02_reg;
                    default: m_sel = '0;
                endcase
            end
            2'd1:
            begin
                unique case (op_reg.col)
                    2'd0:    m_sel = '0;
                    2'd1:    m_sel = $signed({cfg.cos_roll[15], cfg.cos_roll});
                    2'd2:    m_sel = -$signed({cfg.sin_roll[15], cfg.sin_roll});
                    default: m_sel = '0;
                endcase
            end
            2'd2:
            begin
                unique case (op_reg.col)
                    2'd0:    m_sel = -$signed({cfg.sin_pitch[15], cfg.sin_pitch});
                    2'd1:    m_sel = m21_reg;
                    2'd2:    m_sel = m22_reg;
                    default: m_sel = '0;
                endcase
            end
            default: m_sel = '0;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg.ph)
            PH_MAT:
            begin
                mul_a = op_reg.col[1] ? 18'($signed(cfg.cos_pitch))
                                      : 18'($signed(cfg.sin_pitch));
                mul_b = op_reg.col[0] ? 32'($signed(cfg.cos_roll))
                                      : 32'($signed(cfg.sin_roll));
            end
            PH_ROT:
            begin
                mul_a = 18'(m_sel);
                mul_b = op_reg.vec ? 32'($signed(vg_reg[op_reg.col]))
                                   : 32'($signed(va_reg[op_reg.col]));
            end
            PH_GRAV:
            begin
                if (op_reg.col == 2'd0)
                begin
                    mul_a = $signed({2'b00, cfg.alpha});
                    mul_b = g_reg[op_reg.row];
                end
                else
                begin
                    mul_a = 18'sd65536 - $signed({2'b00, cfg.alpha});
                    mul_b = 32'($signed(ca_reg[op_reg.row]));
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding arithmetic on the registered product
    always_comb
    begin
        prod_ext = 52'(prod_reg);
        sum_rot  = (tag_reg.col == 2'd0) ? prod_ext : acc_reg + prod_ext;
        rot_rnd  = (sum_rot + 52'sd16384) >>> 15;
        mat_rnd  = (prod_ext + 52'sd16384) >>> 15;
        mix      = acc_reg + (prod_ext <<< 16);
        g_rnd    = (mix + 52'sd32768) >>> 16;
    end

    // Gravity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg[0] <= '0;
            g_reg[1] <= '0;
            g_reg[2] <= GRAV_RESET_Z;
        end
        else if (tag_vld_reg && (tag_reg.ph == PH_GRAV) && (tag_reg.col == 2'd1))
        begin
            g_reg[tag_reg.row] <= g_rnd[31:0];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            va_reg <= q_head.accel;
            vg_reg <= q_head.gyro;
        end
        prod_reg <= mul_a * mul_b;
        if (tag_vld_reg)
        begin
            unique case (tag_reg.ph)
                PH_MAT:
                begin
                    unique case (tag_reg.col)
                        2'd0:    m01_reg <= mat_rnd[16:0];
                        2'd1:    m02_reg <= mat_rnd[16:0];
                        2'd2:    m21_reg <= mat_rnd[16:0];
                        default: m22_reg <= mat_rnd[16:0];
                    endcase
                end
                PH_ROT:
                begin
                    acc_reg <= sum_rot;
                    if (tag_reg.col == 2'd2)
                    begin
                        if (tag_reg.vec)
                        begin
                            cg_reg[tag_reg.row] <= sat16(rot_rnd[36:0]);
                        end
                        else
                        begin
                            ca_reg[tag_reg.row] <= sat16(rot_rnd[36:0]);
                        end
                    end
                end
                PH_GRAV:
                begin
                    if (tag_reg.col == 2'd0)
                    begin
                        acc_reg <= prod_ext;
                    end
                end
                default: acc_reg <= acc_reg;
            endcase
        end
        // Round the updated estimate to Q7.8
        if (state_reg == B_FIN)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                gr_reg[i] <= sat16(37'(($signed({g_reg[i][31], g_reg[i]}) + 33'sd32768)
                                       >>> 16));
            end
        end
        if (write_out)
        begin
            o_ca_reg <= ca_reg;
            o_cg_reg <= cg_reg;
            o_gr_reg <= gr_reg;
            for (int i = 0; i < AXES; i++)
            begin
                o_ln_reg[i] <= sat16(37'($signed({ca_reg[i][15], ca_reg[i]})
                                       - $signed({gr_reg[i][15], gr_reg[i]})));
            end
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (write_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign corr_accel_x = o_ca_reg[0];
    assign corr_accel_y = o_ca_reg[1];
    assign corr_accel_z = o_ca_reg[2];
    assign corr_gyro_x  = o_cg_reg[0];
    assign corr_gyro_y  = o_cg_reg[1];
    assign corr_gyro_z  = o_cg_reg[2];
    assign grav_x       = o_gr_reg[0];
    assign grav_y       = o_gr_reg[1];
    assign grav_z       = o_gr_reg[2];
    assign lin_x        = o_ln_reg[0];
    assign lin_y        = o_ln_reg[1];
    assign lin_z        = o_ln_reg[2];

endmodule

`default_nettype wire
